// ===== sv/tdg_pkg.sv =====
// ----------------------------------------------------------------------------
// tdg_pkg
// Shared types, register codes and constants of the thermal derate guard.
// ----------------------------------------------------------------------------
package tdg_pkg;

    // field widths
    localparam int TEMP_W    = 12;
    localparam int TICK_W    = 16;
    localparam int RATIO_W   = 16;
    localparam int LIMIT_W   = 16;
    localparam int COUNT_W   = 8;
    localparam int WARM_W    = 2;
    localparam int KIND_W    = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // divider geometry: numerator is a 12 bit difference shifted up by 15
    localparam int Q15_SHIFT = 15;
    localparam int DEN_W     = TEMP_W;
    localparam int NUM_W     = DEN_W + Q15_SHIFT;
    localparam int DIV_CNT_W = $clog2(NUM_W);

    // register reset values
    localparam logic signed [TEMP_W-1:0] FAULT_TEMP_RST  = 12'sd1000;
    localparam logic signed [TEMP_W-1:0] DERATE_TEMP_RST = 12'sd800;
    localparam logic [RATIO_W-1:0]       MIN_RATIO_RST   = 16'd6554;
    localparam logic [LIMIT_W-1:0]       FULL_LIMIT_RST  = 16'd10000;
    localparam logic [COUNT_W-1:0]       SENSOR_CONF_RST = 8'd10;
    localparam logic [COUNT_W-1:0]       OVT_CONF_RST    = 8'd10;
    localparam logic [TICK_W-1:0]        SETTLE_RST      = 16'd1000;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FAULT_TEMP  = 3'd0,
        CFG_DERATE_TEMP = 3'd1,
        CFG_MIN_RATIO   = 3'd2,
        CFG_FULL_LIMIT  = 3'd3,
        CFG_SENSOR_CONF = 3'd4,
        CFG_OVT_CONF    = 3'd5,
        CFG_SETTLE      = 3'd6
    } cfg_idx_t;

    // fault kinds reported with a result
    typedef enum logic [KIND_W-1:0] {
        FAULT_NONE     = 2'd0,
        FAULT_SENSOR   = 2'd1,
        FAULT_OVERTEMP = 2'd2
    } fault_kind_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_DIV,
        ST_MUL,
        ST_DONE
    } tdg_state_t;

    // control between sequencer and divider
    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    // saturating counter increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        r = (c == COUNT_MAX) ? COUNT_MAX : c + COUNT_W'(1);
        return r;
    endfunction

endpackage

// ===== sv/tdg_in_if.sv =====
// ----------------------------------------------------------------------------
// tdg_in_if
// Sample channel: one temperature item per handshake.
// ----------------------------------------------------------------------------
interface tdg_in_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 channel;
    logic                                 sample_valid;
    logic signed [tdg_pkg::TEMP_W-1:0]    temperature_dc;
    logic [tdg_pkg::TICK_W-1:0]           elapsed_ticks;

    modport source (
        output valid, channel, sample_valid, temperature_dc, elapsed_ticks,
        input  ready
    );

    modport sink (
        input  valid, channel, sample_valid, temperature_dc, elapsed_ticks,
        output ready
    );
endinterface

// ===== sv/tdg_out_if.sv =====
// ----------------------------------------------------------------------------
// tdg_out_if
// Result channel: one limit or fault item per handshake.
// ----------------------------------------------------------------------------
interface tdg_out_if;
    logic                             valid;
    logic                             ready;
    logic                             out_channel;
    logic                             limit_update;
    logic [tdg_pkg::LIMIT_W-1:0]      current_limit_ma;
    logic                             fault_enter;
    logic [tdg_pkg::KIND_W-1:0]       fault_kind;

    modport source (
        output valid, out_channel, limit_update, current_limit_ma, fault_enter,
               fault_kind,
        input  ready
    );

    modport sink (
        input  valid, out_channel, limit_update, current_limit_ma, fault_enter,
               fault_kind,
        output ready
    );
endinterface

// ===== sv/thermal_derate_guard_unit.sv =====
// ----------------------------------------------------------------------------
// thermal_derate_guard_unit
// Per-channel temperature guard with sensor and overtemperature fault
// confirmation and linear current derating.
// ----------------------------------------------------------------------------
// sequence: accept, evaluate, output register, when no derating is needed;
//   with derating, the divider (27 steps) and the multiply state come between
// one item at a time: the next enters once a result is in the output register;
//   a finished result waits in the output register while the next item enters
// reset: counters cleared, registers at defaults, no result pending
module thermal_derate_guard_unit #(
    parameter int NUM_CHANNELS   = 2,
    parameter int WARMUP_SAMPLES = 3
) (
    input  logic                            clk,
    input  logic                            rst_n,
    tdg_in_if.sink                          smp,
    tdg_out_if.source                       res,
    input  logic                            cfg_we,
    input  logic [tdg_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tdg_pkg::CFG_DAT_W-1:0]   cfg_data
);
    import tdg_pkg::*;

    // configuration registers
    logic signed [TEMP_W-1:0] fault_temp_reg;
    logic signed [TEMP_W-1:0] derate_temp_reg;
    logic [RATIO_W-1:0]       min_ratio_reg;
    logic [LIMIT_W-1:0]       full_limit_reg;
    logic [COUNT_W-1:0]       sensor_conf_reg;
    logic [COUNT_W-1:0]       ovt_conf_reg;
    logic [TICK_W-1:0]        settle_reg;

    // sequencer and captured item
    tdg_state_t               state_reg, state_next;
    logic                     ch_reg, ch_next;
    logic                     sv_reg, sv_next;
    logic signed [TEMP_W-1:0] temp_reg, temp_next;
    logic [TICK_W-1:0]        ticks_reg, ticks_next;

    // per-channel state
    logic [WARM_W-1:0]        warm_reg [NUM_CHANNELS];
    logic [COUNT_W-1:0]       inv_reg  [NUM_CHANNELS];
    logic [COUNT_W-1:0]       ovt_reg  [NUM_CHANNELS];
    logic [WARM_W-1:0]        cur_warm, new_warm;
    logic [COUNT_W-1:0]       cur_inv, new_inv;
    logic [COUNT_W-1:0]       cur_ovt, new_ovt;
    logic                     ch_wr;
    logic                     ch_present;

    // pending result
    logic                     pend_upd_reg, pend_upd_next;
    logic [LIMIT_W-1:0]       pend_lim_reg, pend_lim_next;
    logic                     pend_flt_reg, pend_flt_next;
    logic [KIND_W-1:0]        pend_kind_reg, pend_kind_next;

    // output register
    logic                     out_valid_reg, out_valid_next;
    logic                     out_ch_reg, out_ch_next;
    logic                     out_upd_reg, out_upd_next;
    logic [LIMIT_W-1:0]       out_lim_reg, out_lim_next;
    logic                     out_flt_reg, out_flt_next;
    logic [KIND_W-1:0]        out_kind_reg, out_kind_next;

    // derate arithmetic
    logic signed [TEMP_W:0]   span_fault_temp;
    logic signed [TEMP_W:0]   span_fault_derate;
    logic                     derate_on;
    div_ctl_t                 div_ctl;
    div_sts_t                 div_sts;
    logic [NUM_W-1:0]         div_quo;
    logic [RATIO_W-1:0]       ratio;
    logic [2*LIMIT_W-1:0]     product;
    logic [LIMIT_W:0]         lim_wide;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fault_temp_reg  <= FAULT_TEMP_RST;
            derate_temp_reg <= DERATE_TEMP_RST;
            min_ratio_reg   <= MIN_RATIO_RST;
            full_limit_reg  <= FULL_LIMIT_RST;
            sensor_conf_reg <= SENSOR_CONF_RST;
            ovt_conf_reg    <= OVT_CONF_RST;
            settle_reg      <= SETTLE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_FAULT_TEMP:  fault_temp_reg  <= cfg_data[TEMP_W-1:0];
                CFG_DERATE_TEMP: derate_temp_reg <= cfg_data[TEMP_W-1:0];
                CFG_MIN_RATIO:   min_ratio_reg   <= cfg_data[RATIO_W-1:0];
                CFG_FULL_LIMIT:  full_limit_reg  <= cfg_data[LIMIT_W-1:0];
                CFG_SENSOR_CONF: sensor_conf_reg <= cfg_data[COUNT_W-1:0];
                CFG_OVT_CONF:    ovt_conf_reg    <= cfg_data[COUNT_W-1:0];
                CFG_SETTLE:      settle_reg      <= cfg_data[TICK_W-1:0];
                default:         ;
            endcase
        end
    end

    // read the addressed channel's counters
    always_comb
    begin
        cur_warm = '0;
        cur_inv  = '0;
        cur_ovt  = '0;
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            if (int'(ch_reg) == i)
            begin
                cur_warm = warm_reg[i];
                cur_inv  = inv_reg[i];
                cur_ovt  = ovt_reg[i];
            end
        end
    end

    assign ch_present = int'(ch_reg) < NUM_CHANNELS;

    // derate window and ratio operands
    assign span_fault_temp   = {fault_temp_reg[TEMP_W-1], fault_temp_reg}
                             - {temp_reg[TEMP_W-1], temp_reg};
    assign span_fault_derate = {fault_temp_reg[TEMP_W-1], fault_temp_reg}
                             - {derate_temp_reg[TEMP_W-1], derate_temp_reg};
    assign derate_on = (temp_reg >= derate_temp_reg)
                    && (fault_temp_reg > derate_temp_reg);

    // clamp ratio and scale the full limit
    assign ratio    = (div_quo[RATIO_W-1:0] < min_ratio_reg) ? min_ratio_reg
                                                             : div_quo[RATIO_W-1:0];
    assign product  = full_limit_reg * ratio;
    assign lim_wide = product[2*LIMIT_W-1:Q15_SHIFT];

    tdg_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .num   ({span_fault_temp[DEN_W-1:0], {Q15_SHIFT{1'b0}}}),
        .den   (span_fault_derate[DEN_W-1:0]),
        .sts   (div_sts),
        .quo   (div_quo)
    );

    // sequencer: next state, counter updates and result assembly
    always_comb
    begin
        state_next     = state_reg;
        ch_next        = ch_reg;
        sv_next        = sv_reg;
        temp_next      = temp_reg;
        ticks_next     = ticks_reg;
        new_warm       = cur_warm;
        new_inv        = cur_inv;
        new_ovt        = cur_ovt;
        ch_wr          = 1'b0;
        pend_upd_next  = pend_upd_reg;
        pend_lim_next  = pend_lim_reg;
        pend_flt_next  = pend_flt_reg;
        pend_kind_next = pend_kind_reg;
        div_ctl.start  = 1'b0;
        out_ch_next    = out_ch_reg;
        out_upd_next   = out_upd_reg;
        out_lim_next   = out_lim_reg;
        out_flt_next   = out_flt_reg;
        out_kind_next  = out_kind_reg;
        out_valid_next = out_valid_reg && !res.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (smp.valid)
                begin
                    ch_next    = smp.channel;
                    sv_next    = smp.sample_valid;
                    temp_next  = smp.temperature_dc;
                    ticks_next = smp.elapsed_ticks;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                pend_upd_next  = 1'b0;
                pend_lim_next  = '0;
                pend_flt_next  = 1'b0;
                pend_kind_next = FAULT_NONE;
                state_next     = ST_DONE;
                if (ch_present)
                begin
                    ch_wr = 1'b1;
                    if (!sv_reg)
                    begin
                        // invalid reading restarts warm-up, counts after settle
                        new_warm = '0;
                        if (ticks_reg >= settle_reg)
                        begin
                            new_inv = sat_inc(cur_inv);
                            if (new_inv >= sensor_conf_reg)
                            begin
                                pend_flt_next  = 1'b1;
                                pend_kind_next = FAULT_SENSOR;
                            end
                        end
                    end
                    else
                    begin
                        new_inv = '0;
                        if (cur_warm < WARM_W'(WARMUP_SAMPLES))
                        begin
                            new_warm = cur_warm + WARM_W'(1);
                        end
                        else if (temp_reg >= fault_temp_reg)
                        begin
                            new_ovt = sat_inc(cur_ovt);
                            if (new_ovt >= ovt_conf_reg)
                            begin
                                pend_flt_next  = 1'b1;
                                pend_kind_next = FAULT_OVERTEMP;
                            end
                        end
                        else
                        begin
                            new_ovt       = '0;
                            pend_upd_next = 1'b1;
                            pend_lim_next = full_limit_reg;
                            if (derate_on)
                            begin
                                div_ctl.start = 1'b1;
                                state_next    = ST_DIV;
                            end
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (div_sts.done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                pend_lim_next = (lim_wide > {1'b0, LIMIT_MAX}) ? LIMIT_MAX
                                                               : lim_wide[LIMIT_W-1:0];
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_valid_next = 1'b1;
                    out_ch_next    = ch_reg;
                    out_upd_next   = pend_upd_reg;
                    out_lim_next   = pend_lim_reg;
                    out_flt_next   = pend_flt_reg;
                    out_kind_next  = pend_kind_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // per-channel counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                warm_reg[i] <= '0;
                inv_reg[i]  <= '0;
                ovt_reg[i]  <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                if (ch_wr && int'(ch_reg) == i)
                begin
                    warm_reg[i] <= new_warm;
                    inv_reg[i]  <= new_inv;
                    ovt_reg[i]  <= new_ovt;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        ch_reg        <= ch_next;
        sv_reg        <= sv_next;
        temp_reg      <= temp_next;
        ticks_reg     <= ticks_next;
        pend_upd_reg  <= pend_upd_next;
        pend_lim_reg  <= pend_lim_next;
        pend_flt_reg  <= pend_flt_next;
        pend_kind_reg <= pend_kind_next;
        out_ch_reg    <= out_ch_next;
        out_upd_reg   <= out_upd_next;
        out_lim_reg   <= out_lim_next;
        out_flt_reg   <= out_flt_next;
        out_kind_reg  <= out_kind_next;
    end

    // channel ports
    assign smp.ready            = (state_reg == ST_IDLE);
    assign res.valid            = out_valid_reg;
    assign res.out_channel      = out_ch_reg;
    assign res.limit_update     = out_upd_reg;
    assign res.current_limit_ma = out_lim_reg;
    assign res.fault_enter      = out_flt_reg;
    assign res.fault_kind       = out_kind_reg;

endmodule

// ===== sv/tdg_div.sv =====
// ----------------------------------------------------------------------------
// tdg_div
// Restoring divider, one quotient bit per cycle, for the derate ratio.
// ----------------------------------------------------------------------------
module tdg_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  tdg_pkg::div_ctl_t             ctl,
    input  logic [tdg_pkg::NUM_W-1:0]     num,
    input  logic [tdg_pkg::DEN_W-1:0]     den,
    output tdg_pkg::div_sts_t             sts,
    output logic [tdg_pkg::NUM_W-1:0]     quo
);
    import tdg_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0]     rem_reg, rem_next;
    logic [NUM_W-1:0]     quo_reg, quo_next;
    logic [DEN_W-1:0]     den_reg, den_next;
    logic [DEN_W:0]       trial;

    // one shift and subtract step
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        trial     = {rem_reg, quo_reg[NUM_W-1]};
        if (ctl.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den_reg})
            begin
                rem_next = DEN_W'(trial - {1'b0, den_reg});
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(NUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quo      = quo_reg;

endmodule

// ===== sv/tdg_checker.sv =====
// ----------------------------------------------------------------------------
// tdg_checker
// Port-level checks of the thermal derate guard, bound to the top level.
// ----------------------------------------------------------------------------
module tdg_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic                          limit_update,
    input logic [tdg_pkg::LIMIT_W-1:0]   current_limit_ma,
    input logic                          fault_enter,
    input logic [tdg_pkg::KIND_W-1:0]    fault_kind
);
    import tdg_pkg::*;

    // one item at a time: no new item right after an accept
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input ready right after an accepted item");

    // a pending result is not dropped
    a_result_held: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid
    ) else $error("result withdrawn before it was taken");

    // a limit and a fault never come together
    a_limit_or_fault: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> !(limit_update && fault_enter)
    ) else $error("limit and fault in the same item");

    // fields without meaning are zero
    a_idle_fields_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid |-> ((limit_update || current_limit_ma == '0)
                    && (fault_enter || fault_kind == FAULT_NONE))
    ) else $error("unused result field not zero");

endmodule

bind thermal_derate_guard_unit tdg_checker u_tdg_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (smp.valid),
    .in_ready         (smp.ready),
    .out_valid        (res.valid),
    .out_ready        (res.ready),
    .limit_update     (res.limit_update),
    .current_limit_ma (res.current_limit_ma),
    .fault_enter      (res.fault_enter),
    .fault_kind       (res.fault_kind)
);

// ===== tb/thermal_derate_guard_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thermal_derate_guard_unit_tb
// Self-checking bench for the thermal derate guard. A driver feeds temperature
// items from a backlog, a shadow of the guard predicts each result, and a
// monitor compares every result item field by field. Register settings change
// between phases while the block is idle; sender and receiver idle at random.
// ----------------------------------------------------------------------------
module thermal_derate_guard_unit_tb;
    import tdg_pkg::*;

    localparam int CHANNELS       = 2;
    localparam int WARMUP_N       = 3;
    localparam int TAIL_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BATCH_ITEMS    = 50;
    localparam int REPORT_MAX     = 10;
    localparam int TEMP_LO        = -400;
    localparam int TEMP_HI        = 2000;
    localparam int BURST_CAP      = 40;
    localparam int SAT_BURST      = 262;

    typedef struct {
        logic                     channel;
        logic                     sample_valid;
        logic signed [TEMP_W-1:0] temp_dc;
        logic [TICK_W-1:0]        ticks;
    } sample_t;

    typedef struct {
        logic               channel;
        logic               limit_update;
        logic [LIMIT_W-1:0] limit_ma;
        logic               fault_enter;
        fault_kind_t        kind;
    } guard_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    tdg_in_if  smp_bus ();
    tdg_out_if res_bus ();

    thermal_derate_guard_unit #(
        .NUM_CHANNELS   (CHANNELS),
        .WARMUP_SAMPLES (WARMUP_N)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .smp       (smp_bus),
        .res       (res_bus),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // shadow of the guard registers
    logic signed [TEMP_W-1:0] lim_fault_dc;
    logic signed [TEMP_W-1:0] lim_derate_dc;
    logic [RATIO_W-1:0]       lim_min_ratio;
    logic [LIMIT_W-1:0]       lim_full_ma;
    logic [COUNT_W-1:0]       conf_sensor;
    logic [COUNT_W-1:0]       conf_ovt;
    logic [TICK_W-1:0]        settle_lim;

    // shadow of the per-channel counters
    logic [WARM_W-1:0]  warm_cnt [CHANNELS];
    logic [COUNT_W-1:0] bad_cnt  [CHANNELS];
    logic [COUNT_W-1:0] hot_cnt  [CHANNELS];

    sample_t       sample_backlog  [$];
    guard_result_t awaited_results [$];
    sample_t       drv_item;
    guard_result_t oldest;

    int idle_pct;
    int stall_pct;
    int batch_no;
    int n_queued;
    int n_accepted;
    int n_checked;
    int n_limits;
    int n_sensor;
    int n_overtemp;
    int n_settings;
    int err_cnt;
    int quiet_cycles;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // guard behavior for one accepted item, updates the shadow counters
    function automatic guard_result_t guard_response(input sample_t s);
        guard_result_t r;
        int            ch;
        int            t;
        int            f;
        int            d;
        longint        ratio;
        longint        lim;
        r.channel      = s.channel;
        r.limit_update = 1'b0;
        r.limit_ma     = '0;
        r.fault_enter  = 1'b0;
        r.kind         = FAULT_NONE;
        ch = s.channel;
        t  = s.temp_dc;
        f  = lim_fault_dc;
        d  = lim_derate_dc;
        if (!s.sample_valid)
        begin
            // invalid reading restarts warm-up, counts only after settling
            warm_cnt[ch] = '0;
            if (s.ticks >= settle_lim)
            begin
                if (bad_cnt[ch] != COUNT_MAX)
                    bad_cnt[ch] = bad_cnt[ch] + 1'b1;
                if (bad_cnt[ch] >= conf_sensor)
                begin
                    r.fault_enter = 1'b1;
                    r.kind        = FAULT_SENSOR;
                end
            end
        end
        else
        begin
            bad_cnt[ch] = '0;
            if (warm_cnt[ch] < WARMUP_N)
            begin
                warm_cnt[ch] = warm_cnt[ch] + 1'b1;
            end
            else if (t >= f)
            begin
                if (hot_cnt[ch] != COUNT_MAX)
                    hot_cnt[ch] = hot_cnt[ch] + 1'b1;
                if (hot_cnt[ch] >= conf_ovt)
                begin
                    r.fault_enter = 1'b1;
                    r.kind        = FAULT_OVERTEMP;
                end
            end
            else
            begin
                // linear derating between derate and fault temperatures
                hot_cnt[ch]    = '0;
                r.limit_update = 1'b1;
                if (t < d || f <= d)
                begin
                    r.limit_ma = lim_full_ma;
                end
                else
                begin
                    ratio = (longint'(f - t) * 64'd32768) / longint'(f - d);
                    if (ratio < lim_min_ratio)
                        ratio = lim_min_ratio;
                    lim = (longint'(lim_full_ma) * ratio) >>> Q15_SHIFT;
                    if (lim > 65535)
                        lim = 65535;
                    r.limit_ma = lim[LIMIT_W-1:0];
                end
            end
        end
        return r;
    endfunction

    function automatic int clip_temp(input int t);
        return (t < TEMP_LO) ? TEMP_LO : ((t > TEMP_HI) ? TEMP_HI : t);
    endfunction

    function automatic int rand_in(input int lo, input int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    task automatic push_sample(input logic ch, input logic v, input int t, input int ticks);
        sample_t s;
        s.channel      = ch;
        s.sample_valid = v;
        s.temp_dc      = t[TEMP_W-1:0];
        s.ticks        = ticks[TICK_W-1:0];
        sample_backlog.push_back(s);
        n_queued++;
    endtask

    // one short stimulus sequence shaped by the current register setting
    task automatic gen_sequence();
        int   kind;
        int   len;
        int   f;
        int   d;
        int   lo;
        int   hi;
        int   t;
        logic c;
        kind = $urandom_range(99);
        c    = $urandom_range(1);
        f    = lim_fault_dc;
        d    = lim_derate_dc;
        lo   = clip_temp(((f < d) ? f : d) - 40);
        hi   = clip_temp(((f > d) ? f : d) + 5);
        if (kind < 45)
        begin
            // valid run around the derating band
            len = $urandom_range(10, 3);
            repeat (len)
            begin
                case ($urandom_range(7))
                    0: t = clip_temp(d - int'($urandom_range(1)));
                    1: t = clip_temp(f - int'($urandom_range(1)));
                    2: t = rand_in(TEMP_LO, TEMP_HI);
                    default: t = rand_in(lo, hi);
                endcase
                push_sample(c ^ ($urandom_range(9) == 0), 1'b1, t, $urandom_range(65535));
            end
        end
        else if (kind < 65)
        begin
            // warm up, then a run of hot items toward an overtemp fault
            repeat (WARMUP_N)
                push_sample(c, 1'b1, rand_in(TEMP_LO, TEMP_HI), $urandom_range(65535));
            len = ((conf_ovt > BURST_CAP) ? BURST_CAP : int'(conf_ovt)) + $urandom_range(3);
            repeat (len)
                push_sample(c ^ ($urandom_range(9) == 0), 1'b1, rand_in(f, TEMP_HI),
                            $urandom_range(65535));
        end
        else if (kind < 80)
        begin
            // run of failed readings toward a sensor fault
            len = ((conf_sensor > BURST_CAP) ? BURST_CAP : int'(conf_sensor)) +
                  $urandom_range(3);
            repeat (len)
                push_sample(c ^ ($urandom_range(9) == 0), 1'b0, rand_in(TEMP_LO, TEMP_HI),
                            ($urandom_range(4) == 0) ? $urandom_range(65535) :
                                                       $urandom_range(65535, settle_lim));
        end
        else
        begin
            // unstructured items
            repeat ($urandom_range(4, 1))
                push_sample($urandom_range(1), $urandom_range(1), rand_in(TEMP_LO, TEMP_HI),
                            $urandom_range(65535));
        end
    endtask

    // wait until every item has been answered, then let the block settle
    task automatic wait_drained();
        do
            @(negedge clk);
        while (sample_backlog.size() != 0 || smp_bus.valid || awaited_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DAT_W-1:0];
        case (idx)
            CFG_FAULT_TEMP:  lim_fault_dc  = value[TEMP_W-1:0];
            CFG_DERATE_TEMP: lim_derate_dc = value[TEMP_W-1:0];
            CFG_MIN_RATIO:   lim_min_ratio = value[RATIO_W-1:0];
            CFG_FULL_LIMIT:  lim_full_ma   = value[LIMIT_W-1:0];
            CFG_SENSOR_CONF: conf_sensor   = value[COUNT_W-1:0];
            CFG_OVT_CONF:    conf_ovt      = value[COUNT_W-1:0];
            CFG_SETTLE:      settle_lim    = value[TICK_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_limits(input int fault, input int derate, input int min_ratio,
                                  input int full, input int s_conf, input int o_conf,
                                  input int settle);
        wait_drained();
        write_reg(CFG_FAULT_TEMP, fault);
        write_reg(CFG_DERATE_TEMP, derate);
        write_reg(CFG_MIN_RATIO, min_ratio);
        write_reg(CFG_FULL_LIMIT, full);
        write_reg(CFG_SENSOR_CONF, s_conf);
        write_reg(CFG_OVT_CONF, o_conf);
        write_reg(CFG_SETTLE, settle);
        @(posedge clk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // random items in two batches, each with its own idling pattern
    task automatic run_random(input int n_items);
        int target;
        repeat (2)
        begin
            case (batch_no % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 9; stall_pct = 9; end
            endcase
            batch_no++;
            target = n_queued + n_items / 2;
            while (n_queued < target)
                gen_sequence();
            while (sample_backlog.size() > 2)
                @(negedge clk);
        end
    endtask

    // stimulus and phases
    initial
    begin
        int f;
        int d;
        smp_bus.valid          = 1'b0;
        smp_bus.channel        = 1'b0;
        smp_bus.sample_valid   = 1'b0;
        smp_bus.temperature_dc = '0;
        smp_bus.elapsed_ticks  = '0;
        res_bus.ready          = 1'b0;
        cfg_we                 = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        lim_fault_dc           = FAULT_TEMP_RST;
        lim_derate_dc          = DERATE_TEMP_RST;
        lim_min_ratio          = MIN_RATIO_RST;
        lim_full_ma            = FULL_LIMIT_RST;
        conf_sensor            = SENSOR_CONF_RST;
        conf_ovt               = OVT_CONF_RST;
        settle_lim             = SETTLE_RST;
        for (int i = 0; i < CHANNELS; i++)
        begin
            warm_cnt[i] = '0;
            bad_cnt[i]  = '0;
            hot_cnt[i]  = '0;
        end
        idle_pct     = 0;
        stall_pct    = 0;
        batch_no     = 0;
        n_queued     = 0;
        n_accepted   = 0;
        n_checked    = 0;
        n_limits     = 0;
        n_sensor     = 0;
        n_overtemp   = 0;
        n_settings   = 1;
        err_cnt      = 0;
        quiet_cycles = 0;
        rst_n        = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed items at reset values: settle edge, warm-up, band edges, clamp
        push_sample(0, 0, 0, 0);
        push_sample(0, 0, -400, 999);
        push_sample(0, 0, 2000, 1000);
        push_sample(0, 1, -400, 65535);
        push_sample(0, 1, 2000, 0);
        push_sample(0, 1, 1000, 16'h5555);
        push_sample(0, 1, -400, 16'haaaa);
        push_sample(0, 1, 799, 2);
        push_sample(0, 1, 800, 3);
        push_sample(0, 1, 900, 4);
        push_sample(0, 1, 999, 5);
        push_sample(0, 1, 1000, 6);
        push_sample(0, 1, 2000, 7);
        push_sample(0, 1, 0, 8);
        push_sample(1, 1, 1500, 9);
        push_sample(1, 1, -1, 10);
        push_sample(1, 1, 512, 11);
        push_sample(1, 0, 0, 65535);
        push_sample(1, 1, 1023, 12);
        push_sample(1, 1, 1024, 13);
        push_sample(1, 1, -2, 14);
        push_sample(1, 1, 950, 15);
        push_sample(1, 1, -400, 16);

        // low extremes, no derating band
        program_limits(-400, -400, 0, 0, 1, 1, 0);
        run_random(2 * BATCH_ITEMS);

        // high extremes, with both counters driven into saturation
        program_limits(2000, -400, 32768, 65535, 255, 255, 65535);
        repeat (WARMUP_N)
            push_sample(0, 1, rand_in(TEMP_LO, TEMP_HI), $urandom_range(65535));
        repeat (SAT_BURST)
            push_sample(0, 1, 2000, $urandom_range(65535));
        repeat (SAT_BURST)
            push_sample(1, 0, rand_in(TEMP_LO, TEMP_HI), 65535);
        run_random(2 * BATCH_ITEMS);

        // ratio floor above one, limit saturates
        program_limits(1000, 0, 65535, 65535, 3, 3, 100);
        run_random(2 * BATCH_ITEMS);

        // zero confirm values
        program_limits(600, 200, 1000, 30000, 0, 0, 500);
        run_random(2 * BATCH_ITEMS);

        // fault threshold below the derate threshold
        program_limits(300, 900, 20000, 5000, 2, 4, 20);
        run_random(2 * BATCH_ITEMS);

        // equal thresholds
        program_limits(700, 700, 16384, 40000, 5, 2, 30000);
        run_random(2 * BATCH_ITEMS);

        // random settings
        repeat (4)
        begin
            f = rand_in(TEMP_LO, TEMP_HI);
            d = ($urandom_range(4) == 0) ? rand_in(TEMP_LO, TEMP_HI) : rand_in(TEMP_LO, f);
            program_limits(f, d, $urandom_range(32768), $urandom_range(65535),
                           ($urandom_range(4) == 0) ? $urandom_range(255, 1) :
                                                      $urandom_range(12, 1),
                           ($urandom_range(4) == 0) ? $urandom_range(255, 1) :
                                                      $urandom_range(12, 1),
                           $urandom_range(65535));
            run_random(2 * BATCH_ITEMS);
        end

        wait_drained();
        $display("run covered %0d items over %0d register settings, %0d results checked",
                 n_accepted, n_settings, n_checked);
        $display("results: %0d limits, %0d sensor faults, %0d overtemp faults, %0d errors",
                 n_limits, n_sensor, n_overtemp, err_cnt);
        if (err_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // driver: hold an item until accepted, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_bus.valid <= 1'b0;
        end
        else
        begin
            if (smp_bus.valid && smp_bus.ready)
            begin
                awaited_results.push_back(guard_response(drv_item));
                n_accepted++;
            end
            if (!smp_bus.valid || smp_bus.ready)
            begin
                if (sample_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    drv_item = sample_backlog.pop_front();
                    smp_bus.valid          <= 1'b1;
                    smp_bus.channel        <= drv_item.channel;
                    smp_bus.sample_valid   <= drv_item.sample_valid;
                    smp_bus.temperature_dc <= drv_item.temp_dc;
                    smp_bus.elapsed_ticks  <= drv_item.ticks;
                end
                else
                begin
                    smp_bus.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result item with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_bus.ready <= 1'b0;
        end
        else
        begin
            if (res_bus.valid && res_bus.ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    err_cnt++;
                    if (err_cnt <= REPORT_MAX)
                        $display("%0t: result item with nothing expected: ch=%0d upd=%0d",
                                 $time, res_bus.out_channel, res_bus.limit_update);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    n_checked++;
                    if (res_bus.out_channel !== oldest.channel ||
                        res_bus.limit_update !== oldest.limit_update ||
                        res_bus.current_limit_ma !== oldest.limit_ma ||
                        res_bus.fault_enter !== oldest.fault_enter ||
                        res_bus.fault_kind !== oldest.kind)
                    begin
                        err_cnt++;
                        if (err_cnt <= REPORT_MAX)
                            $display({"%0t: mismatch exp ch=%0d upd=%0d lim=%0d flt=%0d ",
                                      "kind=%0d got ch=%0d upd=%0d lim=%0d flt=%0d kind=%0d"},
                                     $time, oldest.channel, oldest.limit_update,
                                     oldest.limit_ma, oldest.fault_enter, oldest.kind,
                                     res_bus.out_channel, res_bus.limit_update,
                                     res_bus.current_limit_ma, res_bus.fault_enter,
                                     res_bus.fault_kind);
                    end
                    if (oldest.limit_update)
                        n_limits++;
                    if (oldest.kind == FAULT_SENSOR)
                        n_sensor++;
                    if (oldest.kind == FAULT_OVERTEMP)
                        n_overtemp++;
                end
            end
            res_bus.ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((smp_bus.valid && smp_bus.ready) || (res_bus.valid && res_bus.ready))
            begin
                quiet_cycles <= 0;
            end
            else if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

endmodule
